>>> rtl/hashed_timer_wheel_assert.svh
// Assertion macros for the hashed timer wheel.
`ifndef HASHED_TIMER_WHEEL_ASSERT_SVH
`define HASHED_TIMER_WHEEL_ASSERT_SVH

// Implication checked in the same cycle.
`define HTW_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hashed_timer_wheel check failed");

// Implication checked in the following cycle.
`define HTW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hashed_timer_wheel check failed");

`endif

>>> rtl/htw_pkg.sv
// Shared types and constants of the hashed timer wheel.
package htw_pkg;

	localparam int unsigned SLOT_COUNT_DEF  = 4096;
	localparam int unsigned ENTRY_COUNT_DEF = 64;

	typedef enum logic [2:0] {
		CMD_SET     = 3'd0,
		CMD_START   = 3'd1,
		CMD_REFRESH = 3'd2,
		CMD_REMOVE  = 3'd3,
		CMD_QUERY   = 3'd4,
		CMD_ROLL    = 3'd5
	} cmd_t;

	typedef enum logic [4:0] {
		ST_CLR,
		ST_IDLE,
		ST_MOD,
		ST_DISPATCH,
		ST_UL_RD,
		ST_UL_WR,
		ST_TMO_RD,
		ST_TMO_GOT,
		ST_LK_SLOT,
		ST_LK_RD,
		ST_LK_WR1,
		ST_LK_WR2,
		ST_Q_RD,
		ST_Q_CALC,
		ST_R_CHECK,
		ST_R_HEAD,
		ST_R_EXP,
		ST_R_END,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [5:0]  entry_id;
		logic [15:0] timeout;
		logic [31:0] now;
	} in_item_t;

	typedef struct packed {
		logic        expired_valid;
		logic [5:0]  expired_entry;
		logic [6:0]  expired_count;
		logic [6:0]  active_count;
		logic [15:0] idle_ticks;
		logic [15:0] life_ticks;
		logic        last;
	} out_item_t;

endpackage

>>> rtl/hashed_timer_wheel.sv
// Hashed timer wheel: top level with command sequencer and link memories.
// Usage:
// One input channel (in_valid/in_ready/in_data) takes a command transaction:
// set time, start, refresh, remove, query or roll. One output channel
// (out_valid/out_ready/out_data) returns the results; last marks the final
// result of a command. A roll gives one result per expired entry, or one
// empty result when nothing expires.
// Every command first passes through the remainder unit that reduces the
// time modulo the slot count, then through the memory read and write
// states of its command; start and refresh take more of them than set,
// remove, query and ignored commands. A roll visits up to SLOT_COUNT
// slots and emits one result per expired entry; the slot walk sets the
// length of a roll.
// One command is in flight at a time; in_ready is low while it runs.
// After reset the slot head/tail memories are swept to empty, one slot per
// cycle, with in_ready low.
// When the receiver stalls, the sequencer holds at the next result until the
// output register is free; nothing is dropped.
module hashed_timer_wheel #(
	parameter int unsigned SLOT_COUNT  = htw_pkg::SLOT_COUNT_DEF,
	parameter int unsigned ENTRY_COUNT = htw_pkg::ENTRY_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  htw_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output htw_pkg::out_item_t out_data
);
	import htw_pkg::*;

	localparam int unsigned SW = $clog2(SLOT_COUNT);
	localparam int unsigned EW = $clog2(ENTRY_COUNT);
	localparam int unsigned LW = $clog2(ENTRY_COUNT + 1);
	localparam logic [LW-1:0] NULL_LINK = LW'(ENTRY_COUNT);

	state_t state_q, state_d, ret_q;

	logic [LW-1:0] head_mem [SLOT_COUNT];
	logic [LW-1:0] tail_mem [SLOT_COUNT];
	logic [LW-1:0] next_mem [ENTRY_COUNT];
	logic [LW-1:0] prev_mem [ENTRY_COUNT];
	logic [SW-1:0] eslot_mem [ENTRY_COUNT];
	logic [SW-1:0] etmo_mem [ENTRY_COUNT];

	logic [LW-1:0] hd_rd_q, tl_rd_q, nx_rd_q, pv_rd_q;
	logic [SW-1:0] es_rd_q, et_rd_q;

	logic          slot_re, ent_re;
	logic [SW-1:0] slot_raddr;
	logic          head_we, tail_we, next_we, prev_we, eslot_we, etmo_we;
	logic [SW-1:0] head_waddr, tail_waddr;
	logic [LW-1:0] head_wdata, tail_wdata, next_wdata, prev_wdata;
	logic [EW-1:0] next_waddr, prev_waddr;

	logic [2:0]             cmd_q;
	logic [31:0]            now_q;
	logic [EW-1:0]          e_q;
	logic                   ok_q;
	logic [31:0]            ct_q;
	logic [LW-1:0]          armed_q;
	logic [ENTRY_COUNT-1:0] active_q;
	logic [SW-1:0]          idx_q, tmo_link_q, slot_q, tmo_in_q, clr_q;
	logic [SW:0]            remain_q;
	logic [LW-1:0]          k_q;
	out_item_t              pend_q;
	logic                   pend_v_q;
	logic                   out_valid_q;
	out_item_t              out_q;

	logic          in_acc, out_free, out_load, rem_done, rem_start;
	logic [SW-1:0] rem_val;
	out_item_t     out_next, empty_res, query_res;
	logic [SW-1:0] tmo_eff;
	logic [SW:0]   slot_sum;
	logic [31:0]   roll_diff;
	logic [15:0]   life16;
	logic          act_e;

	assign in_acc    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign rem_start = in_acc;
	assign act_e     = active_q[e_q];
	assign roll_diff = now_q - ct_q;

	htw_rem #(.SLOT_COUNT(SLOT_COUNT)) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rem_start),
		.dividend((cmd_t'(in_data.command) == CMD_ROLL) ? ct_q : in_data.now),
		.done    (rem_done),
		.rem     (rem_val)
	);

	always_comb begin
		tmo_eff  = ({1'b0, in_data.timeout} >= 17'(SLOT_COUNT)) ? '0 : SW'(in_data.timeout);
		slot_sum = {1'b0, rem_val} + {1'b0, tmo_link_q};
		if (slot_sum >= (SW+1)'(SLOT_COUNT)) begin
			slot_sum = slot_sum - (SW+1)'(SLOT_COUNT);
		end
		life16 = 16'(es_rd_q) - 16'(rem_val);
		if (act_e && (es_rd_q < rem_val)) begin
			life16 = life16 + 16'(SLOT_COUNT);
		end
		empty_res              = '0;
		empty_res.active_count = 7'(armed_q);
		empty_res.last         = 1'b1;
		query_res              = empty_res;
		if (ok_q) begin
			query_res.life_ticks = life16;
			query_res.idle_ticks = 16'(et_rd_q) - life16;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR: if (clr_q == SW'(SLOT_COUNT - 1)) state_d = ST_IDLE;
			ST_IDLE: if (in_valid) state_d = ST_MOD;
			ST_MOD: if (rem_done) state_d = ST_DISPATCH;
			ST_DISPATCH: begin
				unique case (cmd_t'(cmd_q))
					CMD_SET: state_d = ST_EMIT;
					CMD_START: begin
						if (!ok_q) state_d = ST_EMIT;
						else if (act_e) state_d = ST_UL_RD;
						else state_d = ST_LK_SLOT;
					end
					CMD_REFRESH, CMD_REMOVE: begin
						state_d = (ok_q && act_e) ? ST_UL_RD : ST_EMIT;
					end
					CMD_QUERY: state_d = ok_q ? ST_Q_RD : ST_Q_CALC;
					CMD_ROLL: state_d = (now_q < ct_q) ? ST_EMIT : ST_R_CHECK;
					default: state_d = ST_EMIT;
				endcase
			end
			ST_UL_RD: state_d = ST_UL_WR;
			ST_UL_WR: state_d = ret_q;
			ST_TMO_RD: state_d = ST_TMO_GOT;
			ST_TMO_GOT: state_d = ST_LK_SLOT;
			ST_LK_SLOT: state_d = ST_LK_RD;
			ST_LK_RD: state_d = ST_LK_WR1;
			ST_LK_WR1: state_d = ST_LK_WR2;
			ST_LK_WR2: state_d = ST_EMIT;
			ST_Q_RD: state_d = ST_Q_CALC;
			ST_Q_CALC: if (out_free) state_d = ST_IDLE;
			ST_R_CHECK: state_d = (remain_q == '0) ? ST_R_END : ST_R_HEAD;
			ST_R_HEAD: state_d = (hd_rd_q < NULL_LINK) ? ST_UL_RD : ST_R_CHECK;
			ST_R_EXP: if (!pend_v_q || out_free) state_d = ST_R_CHECK;
			ST_R_END: if (out_free) state_d = ST_IDLE;
			ST_EMIT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and memory controls
	always_comb begin
		slot_re    = 1'b0;
		slot_raddr = idx_q;
		ent_re     = 1'b0;
		head_we    = 1'b0;
		tail_we    = 1'b0;
		next_we    = 1'b0;
		prev_we    = 1'b0;
		eslot_we   = 1'b0;
		etmo_we    = 1'b0;
		head_waddr = es_rd_q;
		tail_waddr = es_rd_q;
		head_wdata = nx_rd_q;
		tail_wdata = pv_rd_q;
		next_waddr = EW'(pv_rd_q);
		next_wdata = nx_rd_q;
		prev_waddr = EW'(nx_rd_q);
		prev_wdata = pv_rd_q;
		out_load   = 1'b0;
		out_next   = empty_res;
		unique case (state_q)
			ST_CLR: begin
				head_we    = 1'b1;
				tail_we    = 1'b1;
				head_waddr = clr_q;
				tail_waddr = clr_q;
				head_wdata = NULL_LINK;
				tail_wdata = NULL_LINK;
			end
			ST_DISPATCH: etmo_we = (cmd_t'(cmd_q) == CMD_START) && ok_q;
			ST_UL_RD, ST_TMO_RD, ST_Q_RD: ent_re = 1'b1;
			ST_UL_WR: begin
				next_we = (pv_rd_q < NULL_LINK);
				head_we = !(pv_rd_q < NULL_LINK);
				prev_we = (nx_rd_q < NULL_LINK);
				tail_we = !(nx_rd_q < NULL_LINK);
			end
			ST_LK_RD: begin
				slot_re    = 1'b1;
				slot_raddr = slot_q;
			end
			ST_LK_WR1: begin
				eslot_we   = 1'b1;
				next_we    = 1'b1;
				next_waddr = e_q;
				next_wdata = NULL_LINK;
				prev_we    = 1'b1;
				prev_waddr = e_q;
				prev_wdata = tl_rd_q;
				tail_we    = 1'b1;
				tail_waddr = slot_q;
				tail_wdata = LW'(e_q);
				head_we    = !(tl_rd_q < NULL_LINK);
				head_waddr = slot_q;
				head_wdata = LW'(e_q);
			end
			ST_LK_WR2: begin
				next_we    = (tl_rd_q < NULL_LINK);
				next_waddr = EW'(tl_rd_q);
				next_wdata = LW'(e_q);
			end
			ST_Q_CALC: begin
				out_load = out_free;
				out_next = query_res;
			end
			ST_R_CHECK: slot_re = (remain_q != '0);
			ST_R_EXP: begin
				out_load = pend_v_q && out_free;
				out_next = pend_q;
			end
			ST_R_END: begin
				out_load = out_free;
				if (pend_v_q) begin
					out_next      = pend_q;
					out_next.last = 1'b1;
				end
			end
			ST_EMIT: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_waddr] <= head_wdata;
		if (tail_we) tail_mem[tail_waddr] <= tail_wdata;
		if (slot_re) begin
			hd_rd_q <= head_mem[slot_raddr];
			tl_rd_q <= tail_mem[slot_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (next_we) next_mem[next_waddr] <= next_wdata;
		if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
		if (eslot_we) eslot_mem[e_q] <= slot_q;
		if (etmo_we) etmo_mem[e_q] <= tmo_in_q;
		if (ent_re) begin
			nx_rd_q <= next_mem[e_q];
			pv_rd_q <= prev_mem[e_q];
			es_rd_q <= eslot_mem[e_q];
			et_rd_q <= etmo_mem[e_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			ct_q        <= '0;
			armed_q     <= '0;
			active_q    <= '0;
			out_valid_q <= 1'b0;
			pend_v_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR) clr_q <= clr_q + SW'(1);
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (state_q == ST_DISPATCH) begin
				if (cmd_t'(cmd_q) == CMD_SET) ct_q <= now_q;
				pend_v_q <= 1'b0;
			end
			if ((state_q == ST_R_END) && out_free) ct_q <= now_q;
			if (state_q == ST_UL_WR) begin
				active_q[e_q] <= 1'b0;
				if (armed_q != '0) armed_q <= armed_q - LW'(1);
			end
			if (state_q == ST_LK_WR1) begin
				active_q[e_q] <= 1'b1;
				armed_q       <= armed_q + LW'(1);
			end
			if ((state_q == ST_R_EXP) && (!pend_v_q || out_free)) pend_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q    <= in_data.command;
			now_q    <= in_data.now;
			e_q      <= EW'(in_data.entry_id);
			ok_q     <= ({1'b0, in_data.entry_id} < 7'(ENTRY_COUNT));
			tmo_in_q <= tmo_eff;
		end
		if (state_q == ST_DISPATCH) begin
			tmo_link_q <= tmo_in_q;
			k_q        <= '0;
			idx_q      <= rem_val;
			remain_q   <= (roll_diff >= 32'(SLOT_COUNT)) ? (SW+1)'(SLOT_COUNT)
				: roll_diff[SW:0];
			unique case (cmd_t'(cmd_q))
				CMD_START: ret_q <= ST_LK_SLOT;
				CMD_REFRESH: ret_q <= ST_TMO_RD;
				default: ret_q <= ST_EMIT;
			endcase
		end
		if (state_q == ST_TMO_GOT) tmo_link_q <= et_rd_q;
		if (state_q == ST_LK_SLOT) slot_q <= SW'(slot_sum);
		if (state_q == ST_R_HEAD) begin
			if (hd_rd_q < NULL_LINK) begin
				e_q   <= EW'(hd_rd_q);
				ret_q <= ST_R_EXP;
			end else begin
				idx_q    <= (idx_q == SW'(SLOT_COUNT - 1)) ? '0 : idx_q + SW'(1);
				remain_q <= remain_q - (SW+1)'(1);
			end
		end
		if ((state_q == ST_R_EXP) && (!pend_v_q || out_free)) begin
			pend_q               <= '0;
			pend_q.expired_valid <= 1'b1;
			pend_q.expired_entry <= 6'(e_q);
			pend_q.expired_count <= 7'(k_q) + 7'd1;
			pend_q.active_count  <= 7'(armed_q);
			k_q                  <= k_q + LW'(1);
		end
		if (out_load) out_q <= out_next;
	end

	`include "hashed_timer_wheel_assert.svh"

	`HTW_ASSERT_NOW(a_armed_bound, 1'b1, armed_q <= LW'(ENTRY_COUNT))
	`HTW_ASSERT_NOW(a_no_overwrite, out_load, !out_valid_q || out_ready)
	`HTW_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready)
	`HTW_ASSERT_NEXT(a_out_hold, out_valid_q && !out_ready, out_valid_q && $stable(out_q))

endmodule

>>> rtl/htw_rem.sv
// Remainder of a 32-bit value by the slot count, by reciprocal multiplication.
module htw_rem #(
	parameter int unsigned SLOT_COUNT = htw_pkg::SLOT_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [31:0]                   dividend,
	output logic                          done,
	output logic [$clog2(SLOT_COUNT)-1:0] rem
);
	import htw_pkg::*;

	localparam int unsigned SW    = $clog2(SLOT_COUNT);
	localparam int unsigned SH    = 32 + SW;
	localparam logic [63:0] RECIP = (64'd1 << SH) / 64'(SLOT_COUNT);
	localparam logic [16:0] RC_LO = RECIP[16:0];
	localparam logic [15:0] RC_HI = RECIP[32:17];

	logic [31:0]   x_q;
	logic [64:0]   acc_q;
	logic [SW:0]   r0_q;
	logic [SW-1:0] r_q;
	logic [1:0]    step_q;
	logic          busy_q;
	logic          done_q;
	logic [48:0]   p_lo;
	logic [47:0]   p_hi;
	logic [31:0]   quo;
	logic [31:0]   qm;
	logic [31:0]   diff;
	logic [SW-1:0] r_fix;

	// quotient estimate is exact or one low; one conditional subtract fixes it
	always_comb begin
		p_lo = x_q * RC_LO;
		p_hi = x_q * RC_HI;
		quo  = 32'(acc_q >> SH);
		qm   = 32'(quo * 32'(SLOT_COUNT));
		diff = x_q - qm;
		if (r0_q >= (SW+1)'(SLOT_COUNT)) begin
			r_fix = SW'(r0_q - (SW+1)'(SLOT_COUNT));
		end else begin
			r_fix = SW'(r0_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == 2'd3);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= dividend;
		end
		if (busy_q) begin
			unique case (step_q)
				2'd0: acc_q <= {16'd0, p_lo};
				2'd1: acc_q <= acc_q + {p_hi, 17'd0};
				2'd2: r0_q <= diff[SW:0];
				2'd3: r_q <= r_fix;
			endcase
		end
	end

	assign done = done_q;
	assign rem  = r_q;

endmodule
